// ===== hw/rtl/tsfa_pkg.sv =====
`timescale 1ns / 1ps

package tsfa_pkg;

  // sample geometry
  localparam int SampleWidth = 10;
  localparam int SetSize     = 4;

  typedef logic [SampleWidth-1:0] sample_t;
  typedef logic [1:0]             kind_t;
  typedef logic [1:0]             mode_t;
  typedef logic [1:0]             count_t;

  // filter limit after reset
  localparam sample_t LimitReset = sample_t'(10);

  // event codes (code 3 is handled like a timer tick)
  localparam kind_t EV_PEN_IRQ   = 2'd0;
  localparam kind_t EV_CONV_DONE = 2'd1;
  localparam kind_t EV_TIMER     = 2'd2;

  // report codes
  localparam kind_t REPORT_NONE    = 2'd0;
  localparam kind_t REPORT_TOUCH   = 2'd1;
  localparam kind_t REPORT_RELEASE = 2'd2;

  // panel modes
  localparam mode_t MODE_WAIT_DOWN = 2'd0;
  localparam mode_t MODE_WAIT_UP   = 2'd1;
  localparam mode_t MODE_MEASURE   = 2'd2;

  // index of the last sample of a set
  localparam count_t LastIndex = count_t'(SetSize - 1);

  // one incoming event
  typedef struct packed {
    kind_t   event_kind;
    logic    pen_up;
    sample_t x_sample;
    sample_t y_sample;
  } item_t;

  // one outgoing report
  typedef struct packed {
    kind_t   report_kind;
    sample_t x_report;
    sample_t y_report;
    mode_t   panel_mode;
    logic    start_conversion;
    logic    arm_timer;
    logic    rejected;
  } result_t;

endpackage

// ===== hw/rtl/tsfa_event_if.sv =====
`timescale 1ns / 1ps

interface tsfa_event_if import tsfa_pkg::*;;
  logic    valid;
  logic    ready;
  kind_t   event_kind;
  logic    pen_up;
  sample_t x_sample;
  sample_t y_sample;

  modport source (output valid, event_kind, pen_up, x_sample, y_sample, input ready);
  modport sink (input valid, event_kind, pen_up, x_sample, y_sample, output ready);
endinterface

// ===== hw/rtl/tsfa_report_if.sv =====
`timescale 1ns / 1ps

interface tsfa_report_if import tsfa_pkg::*;;
  logic    valid;
  logic    ready;
  kind_t   report_kind;
  sample_t x_report;
  sample_t y_report;
  mode_t   panel_mode;
  logic    start_conversion;
  logic    arm_timer;
  logic    rejected;

  modport source (
    output valid, report_kind, x_report, y_report, panel_mode,
           start_conversion, arm_timer, rejected,
    input  ready
  );
  modport sink (
    input  valid, report_kind, x_report, y_report, panel_mode,
           start_conversion, arm_timer, rejected,
    output ready
  );
endinterface

// ===== hw/rtl/tsfa_cfg_if.sv =====
`timescale 1ns / 1ps

interface tsfa_cfg_if import tsfa_pkg::*;;
  logic    valid;
  logic    ready;
  sample_t error_limit;

  modport source (output valid, error_limit, input ready);
  modport sink (input valid, error_limit, output ready);
endinterface

// ===== hw/rtl/tsfa_seq.sv =====
`timescale 1ns / 1ps

module tsfa_seq import tsfa_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    commit,
  input  item_t   item,
  input  sample_t error_limit,
  output result_t result
);

  count_t  sample_count;
  count_t  sample_count_next;
  logic    store_en;
  sample_t x_samples [SetSize-1];
  sample_t y_samples [SetSize-1];
  logic    x_pass;
  logic    y_pass;

  // deviation check of samples 3 and 4 against the mean of the pair before each
  function automatic logic set_pass(input sample_t v0, input sample_t v1,
                                    input sample_t v2, input sample_t v3,
                                    input sample_t limit);
    logic [SampleWidth:0] s01;
    logic [SampleWidth:0] s12;
    sample_t m1;
    sample_t m2;
    sample_t d1;
    sample_t d2;
    s01 = {1'b0, v0} + {1'b0, v1};
    s12 = {1'b0, v1} + {1'b0, v2};
    m1  = s01[SampleWidth:1];
    m2  = s12[SampleWidth:1];
    d1  = (v2 > m1) ? (v2 - m1) : (m1 - v2);
    d2  = (v3 > m2) ? (v3 - m2) : (m2 - v3);
    return (d1 <= limit) && (d2 <= limit);
  endfunction

  // floored mean of four samples
  function automatic sample_t mean4(input sample_t v0, input sample_t v1,
                                    input sample_t v2, input sample_t v3);
    logic [SampleWidth+1:0] sum;
    sum = {2'b00, v0} + {2'b00, v1} + {2'b00, v2} + {2'b00, v3};
    return sum[SampleWidth+1:2];
  endfunction

  // the fourth sample of a set comes straight from the event
  assign x_pass = set_pass(x_samples[0], x_samples[1], x_samples[2], item.x_sample,
                           error_limit);
  assign y_pass = set_pass(y_samples[0], y_samples[1], y_samples[2], item.y_sample,
                           error_limit);

  // event decode and report
  always_comb begin
    result            = '0;
    sample_count_next = sample_count;
    store_en          = 1'b0;
    if (item.pen_up) begin
      if (item.event_kind == EV_CONV_DONE) begin
        sample_count_next = '0;
      end
      result.report_kind = REPORT_RELEASE;
      result.panel_mode  = MODE_WAIT_DOWN;
    end else if (item.event_kind == EV_CONV_DONE) begin
      if (sample_count == LastIndex) begin
        sample_count_next = '0;
        if (x_pass && y_pass) begin
          result.report_kind = REPORT_TOUCH;
          result.x_report    = mean4(x_samples[0], x_samples[1], x_samples[2],
                                     item.x_sample);
          result.y_report    = mean4(y_samples[0], y_samples[1], y_samples[2],
                                     item.y_sample);
        end else begin
          result.rejected = 1'b1;
        end
        result.panel_mode = MODE_WAIT_UP;
        result.arm_timer  = 1'b1;
      end else begin
        sample_count_next       = sample_count + count_t'(1);
        store_en                = 1'b1;
        result.panel_mode       = MODE_MEASURE;
        result.start_conversion = 1'b1;
      end
    end else begin
      result.panel_mode       = MODE_MEASURE;
      result.start_conversion = 1'b1;
    end
  end

  // sample count
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
    end else if (commit) begin
      sample_count <= sample_count_next;
    end
  end

  // sample store, first three samples of a set
  always_ff @(posedge clk) begin
    if (commit && store_en) begin
      x_samples[sample_count] <= item.x_sample;
      y_samples[sample_count] <= item.y_sample;
    end
  end

  // a stored sample always moves the count up by one
  a_store_count: assert property (@(posedge clk) disable iff (rst)
    commit && store_en |=> sample_count == $past(sample_count) + count_t'(1))
    else $error("sample count did not advance on store");

  // a full set always restarts the count
  a_set_restart: assert property (@(posedge clk) disable iff (rst)
    commit && result.arm_timer |=> sample_count == '0)
    else $error("sample count not cleared after a full set");

  // a stored sample never lands past the third slot
  a_store_slot: assert property (@(posedge clk) disable iff (rst)
    store_en |-> sample_count != LastIndex)
    else $error("store into the last slot");

endmodule

// ===== hw/rtl/touch_sample_filter_average.sv =====
`timescale 1ns / 1ps

// Touch-panel sequencer with a four-sample deviation filter. Each accepted
// event yields exactly one report: the event is captured in an input
// register, decoded and filtered combinationally, and held in the report
// register until taken. A new event can be accepted every cycle while the
// report sink keeps up; the report register is the only point where a stalled
// sink holds up the input, and event ready follows report ready in the same
// cycle. The error limit is written over the cfg channel, which is always
// ready; write it only while no event is in flight.

module touch_sample_filter_average import tsfa_pkg::*; (
  input logic           clk,
  input logic           rst,
  tsfa_event_if.sink    evt,
  tsfa_report_if.source rpt,
  tsfa_cfg_if.sink      cfg
);

  logic    s1_valid;
  item_t   s1_item;
  logic    out_valid;
  result_t out_result;
  result_t result;
  logic    advance;
  logic    accept;
  sample_t error_limit;

  // handshake
  assign advance   = s1_valid && (!out_valid || rpt.ready);
  assign evt.ready = !s1_valid || advance;
  assign accept    = evt.valid && evt.ready;
  assign cfg.ready = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= '{event_kind: evt.event_kind, pen_up: evt.pen_up,
                   x_sample: evt.x_sample, y_sample: evt.y_sample};
    end
  end

  // filter limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      error_limit <= LimitReset;
    end else if (cfg.valid) begin
      error_limit <= cfg.error_limit;
    end
  end

  // decode and filter
  tsfa_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .commit      (advance),
    .item        (s1_item),
    .error_limit (error_limit),
    .result      (result)
  );

  // report register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rpt.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign rpt.valid            = out_valid;
  assign rpt.report_kind      = out_result.report_kind;
  assign rpt.x_report         = out_result.x_report;
  assign rpt.y_report         = out_result.y_report;
  assign rpt.panel_mode       = out_result.panel_mode;
  assign rpt.start_conversion = out_result.start_conversion;
  assign rpt.arm_timer        = out_result.arm_timer;
  assign rpt.rejected         = out_result.rejected;

  // a held event stays in the input register
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_item))
    else $error("pending event lost");

  // a touch report always parks the panel with the timer armed
  a_touch_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.report_kind == REPORT_TOUCH
      |-> out_result.panel_mode == MODE_WAIT_UP && out_result.arm_timer)
    else $error("touch report without wait-up and timer");

  // a rejected set reports nothing and never starts a conversion
  a_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.rejected
      |-> out_result.report_kind == REPORT_NONE && !out_result.start_conversion)
    else $error("rejected set with report or conversion");

  // conversion start and timer arm are exclusive
  a_start_arm: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_result.start_conversion && out_result.arm_timer))
    else $error("conversion and timer both requested");

endmodule
